// ----- rtl/core/iebm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package iebm_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] CFG_WRITE_CYCLE_TICKS = 2'd2;

  localparam logic [6:0]  DEVICE_ADDRESS_RESET    = 7'd80;
  localparam logic [7:0]  ACK_TIMEOUT_TICKS_RESET = 8'd250;
  localparam logic [15:0] WRITE_CYCLE_TICKS_RESET = 16'd10000;

  // Item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Tick on which a received bit is sampled in the SCL high phase.
  localparam logic [15:0] RX_SAMPLE_TICK = 16'd4;

  typedef enum logic [4:0] {
    STEP_IDLE   = 5'd0,
    STEP_STA_A  = 5'd1,
    STEP_STA_B  = 5'd2,
    STEP_TX_LO  = 5'd3,
    STEP_TX_HI  = 5'd4,
    STEP_TX_END = 5'd5,
    STEP_ACK_RL = 5'd6,
    STEP_ACK_HI = 5'd7,
    STEP_ACK_PL = 5'd8,
    STEP_RX_LO  = 5'd9,
    STEP_RX_HI  = 5'd10,
    STEP_NK_LO  = 5'd11,
    STEP_NK_HI  = 5'd12,
    STEP_STO_A  = 5'd13,
    STEP_STO_B  = 5'd14,
    STEP_STO_C  = 5'd15,
    STEP_WAIT   = 5'd16
  } step_t;

  // A classified input word as it travels from the front to the sequencer.
  typedef struct packed {
    logic       is_req;
    logic       req_write;
    logic [7:0] word_addr;
    logic [7:0] write_data;
    logic       sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
    logic       request_ignored;
  } res_t;

  // Number of ticks each fixed-length bus phase lasts; ACK polling and the write wait are timed elsewhere.
  function automatic logic [2:0] phase_len(input step_t s);
    logic [2:0] n;
    unique case (s)
      STEP_ACK_RL: n = 3'd2;
      STEP_RX_HI:  n = 3'd6;
      STEP_IDLE, STEP_ACK_PL, STEP_WAIT: n = 3'd1;
      default:     n = 3'd4;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/iebm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module iebm_front import iebm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] word_addr,
  input  wire logic [7:0] write_data,
  input  wire logic       sda_sample,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_take
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       decoded;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = queue[rd_ptr];

  // Kind three carries no request and is handled as a plain tick.
  always_comb begin
    decoded.is_req     = (kind == KIND_READ) || (kind == KIND_WRITE);
    decoded.req_write  = (kind == KIND_WRITE);
    decoded.word_addr  = word_addr;
    decoded.write_data = write_data;
    decoded.sda_sample = sda_sample;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept} - {1'b0, cmd_take};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/iebm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module iebm_seq import iebm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_take,
  output logic             empty,
  input  wire logic        pop,
  output res_t             res
);

  logic [6:0]  device_address;
  logic [7:0]  ack_timeout_ticks;
  logic [15:0] write_cycle_ticks;

  step_t       step, step_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        is_write, is_write_next;
  logic [7:0]  last_read, last_read_next;
  logic        error_flag, error_flag_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic        done, ignored;

  res_t        out_queue [2];
  logic        out_wr_ptr;
  logic        out_rd_ptr;
  logic [1:0]  out_count;
  logic        out_pop;
  res_t        result;

  assign out_pop  = pop && !empty;
  assign empty    = (out_count == 2'd0);
  assign cmd_take = cmd_valid && ((out_count != 2'd2) || out_pop);
  assign res      = out_queue[out_rd_ptr];

  function automatic logic [7:0] tx_byte(input logic [1:0] pos, input logic wr,
                                         input logic [6:0] dev, input logic [7:0] addr,
                                         input logic [7:0] data);
    logic [7:0] b;
    if (pos == 2'd0) begin
      b = {dev, 1'b0};
    end else if (pos == 2'd1) begin
      b = addr;
    end else if (wr) begin
      b = data;
    end else begin
      b = {dev, 1'b1};
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address    <= DEVICE_ADDRESS_RESET;
      ack_timeout_ticks <= ACK_TIMEOUT_TICKS_RESET;
      write_cycle_ticks <= WRITE_CYCLE_TICKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS:    device_address    <= cfg_data[6:0];
        CFG_ACK_TIMEOUT_TICKS: ack_timeout_ticks <= cfg_data[7:0];
        CFG_WRITE_CYCLE_TICKS: write_cycle_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state of the bus sequencer for the word at the head of the queue.
  always_comb begin
    logic [1:0]  pos1;
    logic [16:0] tick1;
    step_next         = step;
    bit_count_next    = bit_count;
    tick_count_next   = tick_count;
    shift_byte_next   = shift_byte;
    held_address_next = held_address;
    held_data_next    = held_data;
    is_write_next     = is_write;
    last_read_next    = last_read;
    error_flag_next   = error_flag;
    byte_pos_next     = byte_pos;
    done              = 1'b0;
    ignored           = 1'b0;
    pos1              = byte_pos + 2'd1;
    tick1             = {1'b0, tick_count} + 17'd1;

    if (cmd.is_req) begin
      if (step != STEP_IDLE) begin
        ignored = 1'b1;
      end else begin
        held_address_next = cmd.word_addr;
        held_data_next    = cmd.write_data;
        is_write_next     = cmd.req_write;
        error_flag_next   = 1'b0;
        byte_pos_next     = 2'd0;
        bit_count_next    = 4'd0;
        step_next         = STEP_STA_A;
        tick_count_next   = 16'd0;
      end
    end else if (step == STEP_IDLE) begin
      tick_count_next = 16'd0;
    end else if (step == STEP_ACK_PL) begin
      if (!cmd.sda_sample) begin
        // Acknowledge seen: move on to the next byte or phase of the transfer.
        byte_pos_next   = pos1;
        tick_count_next = 16'd0;
        if ((is_write && pos1 == 2'd3) || (!is_write && pos1 == 2'd2)) begin
          step_next = is_write ? STEP_STO_A : STEP_STA_A;
        end else if (is_write || pos1 == 2'd1) begin
          shift_byte_next = tx_byte(pos1, is_write, device_address, held_address,
                                    held_data);
          bit_count_next  = 4'd0;
          step_next       = STEP_TX_LO;
        end else begin
          shift_byte_next = 8'd0;
          bit_count_next  = 4'd0;
          step_next       = STEP_RX_LO;
        end
      end else begin
        tick_count_next = tick1[15:0];
        if (tick1 > {9'd0, ack_timeout_ticks}) begin
          error_flag_next = 1'b1;
          step_next       = STEP_STO_A;
          tick_count_next = 16'd0;
        end
      end
    end else if (step == STEP_WAIT) begin
      tick_count_next = tick1[15:0];
      if (tick1 >= {1'b0, write_cycle_ticks}) begin
        step_next       = STEP_IDLE;
        tick_count_next = 16'd0;
        done            = 1'b1;
      end
    end else begin
      tick_count_next = tick1[15:0];
      if (step == STEP_RX_HI && tick1[15:0] == RX_SAMPLE_TICK) begin
        shift_byte_next = {shift_byte[6:0], cmd.sda_sample};
      end
      if (tick1 >= {14'd0, phase_len(step)}) begin
        tick_count_next = 16'd0;
        unique case (step)
          STEP_STA_A: step_next = STEP_STA_B;
          STEP_STA_B: begin
            shift_byte_next = tx_byte(byte_pos, is_write, device_address,
                                      held_address, held_data);
            bit_count_next  = 4'd0;
            step_next       = STEP_TX_LO;
          end
          STEP_TX_LO: step_next = STEP_TX_HI;
          STEP_TX_HI: step_next = STEP_TX_END;
          STEP_TX_END: begin
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_count + 4'd1;
            step_next       = (bit_count_next >= 4'd8) ? STEP_ACK_RL : STEP_TX_LO;
          end
          STEP_ACK_RL: step_next = STEP_ACK_HI;
          STEP_ACK_HI: step_next = STEP_ACK_PL;
          STEP_RX_LO:  step_next = STEP_RX_HI;
          STEP_RX_HI: begin
            bit_count_next = bit_count + 4'd1;
            step_next      = (bit_count_next >= 4'd8) ? STEP_NK_LO : STEP_RX_LO;
          end
          STEP_NK_LO: step_next = STEP_NK_HI;
          STEP_NK_HI: step_next = STEP_STO_A;
          STEP_STO_A: step_next = STEP_STO_B;
          STEP_STO_B: step_next = STEP_STO_C;
          default: begin
            if (!error_flag && is_write && write_cycle_ticks != 16'd0) begin
              step_next = STEP_WAIT;
            end else begin
              if (!error_flag && !is_write) begin
                last_read_next = shift_byte;
              end
              step_next = STEP_IDLE;
              done      = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Pin levels and status after this word.
  always_comb begin
    logic sda_bit;
    sda_bit = shift_byte_next[7];
    result.sda_level        = 1'b1;
    result.scl_level        = 1'b1;
    result.sda_drive_enable = 1'b1;
    unique case (step_next)
      STEP_STA_B, STEP_STO_B: result.sda_level = 1'b0;
      STEP_TX_LO, STEP_TX_END: begin
        result.scl_level = 1'b0;
        result.sda_level = sda_bit;
      end
      STEP_TX_HI: result.sda_level = sda_bit;
      STEP_ACK_RL, STEP_RX_LO: begin
        result.scl_level        = 1'b0;
        result.sda_drive_enable = 1'b0;
      end
      STEP_ACK_HI, STEP_ACK_PL, STEP_RX_HI: result.sda_drive_enable = 1'b0;
      STEP_NK_LO: result.scl_level = 1'b0;
      STEP_STO_A: begin
        result.scl_level = 1'b0;
        result.sda_level = 1'b0;
      end
      default: ;
    endcase
    result.busy_res        = (step_next != STEP_IDLE);
    result.done_res        = done;
    result.read_data       = last_read_next;
    result.ack_error       = error_flag_next;
    result.request_ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_IDLE;
      bit_count    <= 4'd0;
      tick_count   <= 16'd0;
      shift_byte   <= 8'd0;
      held_address <= 8'd0;
      held_data    <= 8'd0;
      is_write     <= 1'b0;
      last_read    <= 8'd0;
      error_flag   <= 1'b0;
      byte_pos     <= 2'd0;
    end else if (cmd_take) begin
      step         <= step_next;
      bit_count    <= bit_count_next;
      tick_count   <= tick_count_next;
      shift_byte   <= shift_byte_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
      is_write     <= is_write_next;
      last_read    <= last_read_next;
      error_flag   <= error_flag_next;
      byte_pos     <= byte_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_queue[out_wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= 2'd0;
    end else begin
      if (cmd_take) begin
        out_wr_ptr <= ~out_wr_ptr;
      end
      if (out_pop) begin
        out_rd_ptr <= ~out_rd_ptr;
      end
      out_count <= out_count + {1'b0, cmd_take} - {1'b0, out_pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/i2c_eeprom_byte_master_unit.sv -----
// A word's result is registered: the sequencer takes each accepted word from the input
// queue and writes its result into the result queue. Throughput: one word per cycle, set
// by the sequencer updating its state once a cycle, while the result queue is not full
// or is popped. Both sides have two-entry queues, so push and pop stall independently.
// Reset (rst, synchronous, active high) empties both queues, returns the bus sequencer to
// idle, and restores the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_byte_master_unit import iebm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  word_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic        sda_sample,
  output logic             empty,
  input  wire logic        pop,
  output logic             scl_level,
  output logic             sda_level,
  output logic             sda_drive_enable,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_data,
  output logic             ack_error,
  output logic             request_ignored
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;
  res_t res;

  iebm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .word_addr  (word_addr),
    .write_data (write_data),
    .sda_sample (sda_sample),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  iebm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign scl_level        = res.scl_level;
  assign sda_level        = res.sda_level;
  assign sda_drive_enable = res.sda_drive_enable;
  assign busy_res         = res.busy_res;
  assign done_res         = res.done_res;
  assign read_data        = res.read_data;
  assign ack_error        = res.ack_error;
  assign request_ignored  = res.request_ignored;

endmodule
`default_nettype wire

// ----- bench/tb_i2c_eeprom_byte_master_unit.sv -----
`timescale 1ns / 1ps
module tb_i2c_eeprom_byte_master_unit;
  import iebm_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int NO_REFUSAL = 4;

  class byte_access_scoreboard;
    logic [6:0]  dev_addr;
    logic [7:0]  ack_limit;
    logic [15:0] prog_ticks;
    step_t       seq_step;
    int unsigned bits_done;
    int unsigned ticks;
    int unsigned byte_idx;
    logic [7:0]  shreg;
    logic [7:0]  addr_hold;
    logic [7:0]  data_hold;
    logic [7:0]  rd_byte;
    bit          wr_op;
    bit          err;
    res_t        due_results[$];
    int          errors;

    function new();
      dev_addr = DEVICE_ADDRESS_RESET;
      ack_limit = ACK_TIMEOUT_TICKS_RESET;
      prog_ticks = WRITE_CYCLE_TICKS_RESET;
      seq_step = STEP_IDLE;
      bits_done = 0;
      ticks = 0;
      byte_idx = 0;
      shreg = '0;
      addr_hold = '0;
      data_hold = '0;
      rd_byte = '0;
      wr_op = 0;
      err = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_DEVICE_ADDRESS:    dev_addr = val[6:0];
        CFG_ACK_TIMEOUT_TICKS: ack_limit = val[7:0];
        CFG_WRITE_CYCLE_TICKS: prog_ticks = val;
        default: ;
      endcase
    endfunction

    function void enter(step_t s);
      seq_step = s;
      ticks = 0;
    endfunction

    function int unsigned phase_ticks(step_t s);
      case (s)
        STEP_ACK_RL: return 2;
        STEP_RX_HI:  return 6;
        STEP_IDLE, STEP_ACK_PL, STEP_WAIT: return 1;
        default:     return 4;
      endcase
    endfunction

    function void load_next_byte();
      if (byte_idx == 0) shreg = {dev_addr, 1'b0};
      else if (byte_idx == 1) shreg = addr_hold;
      else if (wr_op) shreg = data_hold;
      else shreg = {dev_addr, 1'b1};
      bits_done = 0;
      enter(STEP_TX_LO);
    endfunction

    function void after_ack();
      byte_idx = (byte_idx + 1) & 3;
      if (wr_op) begin
        if (byte_idx >= 3) enter(STEP_STO_A);
        else load_next_byte();
      end else if (byte_idx == 1) begin
        load_next_byte();
      end else if (byte_idx == 2) begin
        // A read goes back through a repeated START before the read address.
        enter(STEP_STA_A);
      end else begin
        shreg = '0;
        bits_done = 0;
        enter(STEP_RX_LO);
      end
    endfunction

    // Advances the bus sequence by one tick; returns whether it finished.
    function bit advance_tick(logic sda);
      if (seq_step == STEP_IDLE) begin
        enter(STEP_IDLE);
        return 0;
      end
      if (seq_step == STEP_ACK_PL) begin
        if (!sda) begin
          after_ack();
        end else begin
          ticks++;
          if (ticks > ack_limit) begin
            err = 1;
            enter(STEP_STO_A);
          end
        end
        return 0;
      end
      if (seq_step == STEP_WAIT) begin
        ticks++;
        if (ticks >= prog_ticks) begin
          enter(STEP_IDLE);
          return 1;
        end
        return 0;
      end
      ticks++;
      if (seq_step == STEP_RX_HI && ticks == 4) shreg = {shreg[6:0], sda};
      if (ticks < phase_ticks(seq_step)) return 0;
      case (seq_step)
        STEP_STA_A:  enter(STEP_STA_B);
        STEP_STA_B:  load_next_byte();
        STEP_TX_LO:  enter(STEP_TX_HI);
        STEP_TX_HI:  enter(STEP_TX_END);
        STEP_TX_END: begin
          shreg = shreg << 1;
          bits_done++;
          if (bits_done >= 8) enter(STEP_ACK_RL);
          else enter(STEP_TX_LO);
        end
        STEP_ACK_RL: enter(STEP_ACK_HI);
        STEP_ACK_HI: enter(STEP_ACK_PL);
        STEP_RX_LO:  enter(STEP_RX_HI);
        STEP_RX_HI: begin
          bits_done++;
          if (bits_done >= 8) enter(STEP_NK_LO);
          else enter(STEP_RX_LO);
        end
        STEP_NK_LO:  enter(STEP_NK_HI);
        STEP_NK_HI:  enter(STEP_STO_A);
        STEP_STO_A:  enter(STEP_STO_B);
        STEP_STO_B:  enter(STEP_STO_C);
        STEP_STO_C: begin
          if (!err && wr_op && prog_ticks != 0) begin
            enter(STEP_WAIT);
          end else begin
            if (!err && !wr_op) rd_byte = shreg;
            enter(STEP_IDLE);
            return 1;
          end
        end
        default: ;
      endcase
      return 0;
    endfunction

    // Pin drive as {drive enable, SDA, SCL}.
    function logic [2:0] pin_drive();
      case (seq_step)
        STEP_STA_B, STEP_STO_B:               return 3'b101;
        STEP_TX_LO, STEP_TX_END:              return {1'b1, shreg[7], 1'b0};
        STEP_TX_HI:                           return {1'b1, shreg[7], 1'b1};
        STEP_ACK_RL, STEP_RX_LO:              return 3'b010;
        STEP_ACK_HI, STEP_ACK_PL, STEP_RX_HI: return 3'b011;
        STEP_NK_LO:                           return 3'b110;
        STEP_STO_A:                           return 3'b100;
        default:                              return 3'b111;
      endcase
    endfunction

    function void note_word(logic [1:0] k, logic [7:0] wa, logic [7:0] wd, logic sda);
      res_t r;
      logic [2:0] pins;
      bit fin;
      bit dropped;
      fin = 0;
      dropped = 0;
      if (k == KIND_READ || k == KIND_WRITE) begin
        if (seq_step != STEP_IDLE) begin
          dropped = 1;
        end else begin
          addr_hold = wa;
          data_hold = wd;
          wr_op = (k == KIND_WRITE);
          err = 0;
          byte_idx = 0;
          bits_done = 0;
          enter(STEP_STA_A);
        end
      end else begin
        fin = advance_tick(sda);
      end
      pins = pin_drive();
      r.scl_level = pins[0];
      r.sda_level = pins[1];
      r.sda_drive_enable = pins[2];
      r.busy_res = (seq_step != STEP_IDLE);
      r.done_res = fin;
      r.read_data = rd_byte;
      r.ack_error = err;
      r.request_ignored = dropped;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result word %0h arrived with nothing outstanding", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("scl_level", want.scl_level, got.scl_level);
      compare_field("sda_level", want.sda_level, got.sda_level);
      compare_field("sda_drive_enable", want.sda_drive_enable, got.sda_drive_enable);
      compare_field("busy_res", want.busy_res, got.busy_res);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("ack_error", want.ack_error, got.ack_error);
      compare_field("request_ignored", want.request_ignored, got.request_ignored);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_DEVICE_ADDRESS;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = KIND_TICK;
  logic [7:0]  word_addr = '0;
  logic [7:0]  write_data = '0;
  logic        sda_sample = 1'b1;
  logic        empty;
  logic        pop = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        sda_drive_enable;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_data;
  logic        ack_error;
  logic        request_ignored;

  byte_access_scoreboard sb;
  bit idle_enable = 1'b1;
  int pop_hold = 0;

  i2c_eeprom_byte_master_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("tb_i2c_eeprom_byte_master_unit: done, errors");
    $finish;
  end

  // Result side: check every popped word and stall in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        sb.check_word(res_t'({scl_level, sda_level, sda_drive_enable, busy_res, done_res,
                              read_data, ack_error, request_ignored}));
      if (pop_hold > 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        pop_hold = $urandom_range(1, 15) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Push leaves push high after acceptance so that words can stream back to back.
  task automatic push_word(logic [1:0] k, logic [7:0] wa, logic [7:0] wd, logic sda);
    kind <= k;
    word_addr <= wa;
    write_data <= wd;
    sda_sample <= sda;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(k, wa, wd, sda);
    if (idle_enable && $urandom_range(0, 15) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [6:0] dev, logic [7:0] tmo, logic [15:0] wcyc);
    logic [1:0]  regs [3];
    logic [15:0] vals [3];
    regs = '{CFG_DEVICE_ADDRESS, CFG_ACK_TIMEOUT_TICKS, CFG_WRITE_CYCLE_TICKS};
    vals = '{{9'd0, dev}, {8'd0, tmo}, wcyc};
    for (int i = 0; i < 3; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  // One request followed by ticks, with the slave answering as a real EEPROM would,
  // except that it withholds its ACK on the byte numbered refuse_at.
  task automatic run_transfer(bit wr, logic [7:0] wa, logic [7:0] wd, logic [7:0] rx_byte,
                              int refuse_at, int noise_pct);
    logic [1:0] k;
    logic s;
    push_word(wr ? KIND_WRITE : KIND_READ, wa, wd, 1'($urandom_range(0, 1)));
    while (sb.seq_step != STEP_IDLE) begin
      k = KIND_TICK;
      s = 1'($urandom_range(0, 1));
      if ($urandom_range(1, 100) <= noise_pct) k = 2'($urandom_range(1, 3));
      if (sb.seq_step == STEP_ACK_PL)
        s = (sb.byte_idx == refuse_at) ? 1'b1 : ($urandom_range(0, 3) == 0);
      else if (sb.seq_step == STEP_RX_HI)
        s = rx_byte[7 - sb.bits_done];
      push_word(k, 8'($urandom), 8'($urandom), s);
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle ticks, a spare kind and a read of all ones.
    push_word(KIND_TICK, 8'h00, 8'h00, 1'b0);
    push_word(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
    push_word(KIND_SPARE, 8'h5A, 8'hA5, 1'b0);
    run_transfer(1'b0, 8'h00, 8'h00, 8'hFF, NO_REFUSAL, 0);
    drain_results();

    // A one-tick timeout: a read that aborts on its first ACK and keeps the last read byte.
    set_config(7'd0, 8'd1, 16'd0);
    run_transfer(1'b0, 8'h3C, 8'h00, 8'h81, 0, 0);
    drain_results();

    // A write that clears the error flag, completes and then holds busy for a short
    // programming time, with requests arriving while busy. This last part runs without
    // idling.
    set_config(7'($urandom_range(0, 127)), 8'd255, 16'd5);
    idle_enable = 1'b0;
    run_transfer(1'b1, 8'($urandom), 8'($urandom), 8'h00, NO_REFUSAL, 3);
    drain_results();

    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("tb_i2c_eeprom_byte_master_unit: done, clean");
    else
      $display("tb_i2c_eeprom_byte_master_unit: done, errors");
    $finish;
  end

endmodule
